@@ rtl/core/ddd_pkg.sv @@
// shared types and constants for the dihedral duplicate detector
// no dependencies; imported by every module in rtl/core
package ddd_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int ARMS        = 6;
  localparam int WORD_W      = 32;
  localparam int REC_W       = ARMS * WORD_W;
  localparam int ADDR_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int OUT_CNT_W   = 11;

  typedef logic [ARMS-1:0][WORD_W-1:0] rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_WRITE,
    ST_OUT
  } state_t;

  // store access from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    rec_t              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // compare unit result
  typedef struct packed {
    logic valid;
    logic hit;
  } cmp_res_t;

  // sequencer status seen by the top level
  typedef struct packed {
    state_t           state;
    logic [CNT_W-1:0] count;
    logic             match_seen;
  } ctrl_stat_t;

endpackage

@@ rtl/core/ddd_store.sv @@
// record memory: one write port, one registered read port
// depends on ddd_pkg
module ddd_store (
  input  logic              clk,
  input  ddd_pkg::mem_req_t mreq,
  output ddd_pkg::rec_t     rd_data
);
  import ddd_pkg::*;

  rec_t mem [MAX_RECORDS];

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rd_data <= mem[mreq.rd_addr];
    end
  end

endmodule

@@ rtl/core/ddd_cmp.sv @@
// shared compare unit: new record against one stored record under all
// twelve rotations and reflections, result registered; depends on ddd_pkg
module ddd_cmp (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ddd_pkg::rec_t     rec_a,
  input  ddd_pkg::rec_t     rec_b,
  output ddd_pkg::cmp_res_t res
);
  import ddd_pkg::*;

  logic [ARMS-1:0] fwd_ok;
  logic [ARMS-1:0] bwd_ok;

  genvar s, k;
  generate
    for (s = 0; s < ARMS; s++) begin : g_shift
      logic [ARMS-1:0] fwd_eq;
      logic [ARMS-1:0] bwd_eq;
      for (k = 0; k < ARMS; k++) begin : g_arm
        localparam int FI = (s + k) % ARMS;
        localparam int BI = (s + ARMS - k) % ARMS;
        assign fwd_eq[k] = (rec_a[k] == rec_b[FI]);
        assign bwd_eq[k] = (rec_a[k] == rec_b[BI]);
      end
      assign fwd_ok[s] = &fwd_eq;
      assign bwd_ok[s] = &bwd_eq;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= in_valid;
    end
    res.hit <= (|fwd_ok) | (|bwd_ok);
  end

endmodule

@@ rtl/core/ddd_ctrl.sv @@
// sequencer: accepts records, scans the store through the compare unit,
// writes the record and issues the verdict; depends on ddd_pkg
module ddd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ddd_pkg::WORD_W-1:0]    arm0,
  input  logic [ddd_pkg::WORD_W-1:0]    arm1,
  input  logic [ddd_pkg::WORD_W-1:0]    arm2,
  input  logic [ddd_pkg::WORD_W-1:0]    arm3,
  input  logic [ddd_pkg::WORD_W-1:0]    arm4,
  input  logic [ddd_pkg::WORD_W-1:0]    arm5,
  input  logic                          last_record,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          twins_found,
  output logic                          overflow,
  output logic [ddd_pkg::OUT_CNT_W-1:0] record_count,
  output ddd_pkg::mem_req_t             mreq,
  output ddd_pkg::rec_t                 rec,
  output logic                          rd_pending,
  input  ddd_pkg::cmp_res_t             cres,
  output ddd_pkg::ctrl_stat_t           stat
);
  import ddd_pkg::*;

  state_t           state;
  state_t           state_next;
  logic             last_flag;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_idx;
  logic             match_seen;
  logic             overflow_seen;
  logic             accept;
  logic             full;
  logic             scan_end;
  logic             out_load;

  assign full     = (count >= CNT_W'(MAX_RECORDS));
  assign scan_end = (scan_idx == count - CNT_W'(1));
  assign accept   = in_valid && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (full) begin
            state_next = last_record ? ST_OUT : ST_IDLE;
          end else if ((count == '0) || match_seen) begin
            state_next = ST_WRITE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_WRITE;
      ST_WRITE:  state_next = last_flag ? ST_OUT : ST_IDLE;
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != ST_IDLE);
    mreq.rd_en   = (state == ST_SCAN);
    mreq.rd_addr = scan_idx[ADDR_W-1:0];
    mreq.wr_en   = (state == ST_WRITE);
    mreq.wr_addr = count[ADDR_W-1:0];
    mreq.wr_data = rec;
    out_load     = (state == ST_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      match_seen    <= 1'b0;
      overflow_seen <= 1'b0;
      rd_pending    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= mreq.rd_en;
      if (cres.valid && cres.hit) begin
        match_seen <= 1'b1;
      end
      if (accept && full) begin
        overflow_seen <= 1'b1;
      end
      if (state == ST_WRITE) begin
        count <= count + CNT_W'(1);
      end
      if (out_load) begin
        out_valid     <= 1'b1;
        count         <= '0;
        match_seen    <= 1'b0;
        overflow_seen <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rec       <= {arm5, arm4, arm3, arm2, arm1, arm0};
      last_flag <= last_record;
      scan_idx  <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (out_load) begin
      twins_found  <= match_seen;
      overflow     <= overflow_seen;
      record_count <= OUT_CNT_W'(count);
    end
  end

  assign stat.state      = state;
  assign stat.count      = count;
  assign stat.match_seen = match_seen;

endmodule

@@ rtl/core/dihedral_duplicate_detector.sv @@
// dihedral duplicate detector top level: sequencer, record store, compare unit
// a record arriving with records already stored is scanned (one store read per cycle into the
// shared compare unit), then passes the drain states DRAIN1 and DRAIN2 and one write;
// with the set empty or a match already seen it goes straight to the write, and once
// the store is full it is dropped with overflow flagged; a marked record then loads the
// verdict, waiting while an older one is stalled; sync reset empties the set, store kept
module dihedral_duplicate_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ddd_pkg::WORD_W-1:0]    arm0,
  input  logic [ddd_pkg::WORD_W-1:0]    arm1,
  input  logic [ddd_pkg::WORD_W-1:0]    arm2,
  input  logic [ddd_pkg::WORD_W-1:0]    arm3,
  input  logic [ddd_pkg::WORD_W-1:0]    arm4,
  input  logic [ddd_pkg::WORD_W-1:0]    arm5,
  input  logic                          last_record,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          twins_found,
  output logic                          overflow,
  output logic [ddd_pkg::OUT_CNT_W-1:0] record_count
);
  import ddd_pkg::*;

  mem_req_t   mreq;
  rec_t       rec;
  rec_t       rd_data;
  logic       rd_pending;
  cmp_res_t   cres;
  ctrl_stat_t stat;

  ddd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .arm0         (arm0),
    .arm1         (arm1),
    .arm2         (arm2),
    .arm3         (arm3),
    .arm4         (arm4),
    .arm5         (arm5),
    .last_record  (last_record),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .twins_found  (twins_found),
    .overflow     (overflow),
    .record_count (record_count),
    .mreq         (mreq),
    .rec          (rec),
    .rd_pending   (rd_pending),
    .cres         (cres),
    .stat         (stat)
  );

  ddd_store u_store (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  ddd_cmp u_cmp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_pending),
    .rec_a    (rec),
    .rec_b    (rd_data),
    .res      (cres)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(MAX_RECORDS))
    else $error("stored count above capacity");

  // reads only touch entries already written in this set
  a_read_in_set: assert property (@(posedge clk) disable iff (rst)
    mreq.rd_en |-> (CNT_W'(mreq.rd_addr) < stat.count))
    else $error("store read beyond stored records");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mreq.wr_en |-> (stat.count < CNT_W'(MAX_RECORDS)))
    else $error("store write while full");

  // a verdict leaves the set empty
  a_verdict_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (stat.count == '0) && !stat.match_seen)
    else $error("set not cleared after verdict");

endmodule
